>>> hdl/lcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and fixed field widths for the longest common substring block.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int OP_W         = 2;
    localparam int SYM_W        = 8;
    localparam int LEN_OUT_W    = 7;
    localparam int FIRST_OUT_W  = 12;
    localparam int SECOND_OUT_W = 6;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 32;

    typedef enum logic [OP_W-1:0] {
        OP_START  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_STREAM = 2'd2
    } op_t;

    // control that travels with one row of the table through the cells
    typedef struct packed {
        logic valid;
        logic compute;
        logic last;
    } row_ctrl_t;

endpackage
`default_nettype wire

>>> hdl/lcs_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_cell
// One second-string position: holds its byte and diagonal run, updates the
// run for the row passing through and carries the row's running best along.
// ----------------------------------------------------------------------------
module lcs_cell
    import lcs_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int J_W   = 6,
    parameter int CNT_W = 7,
    parameter int LEN_W = 7,
    parameter int POS_W = 12
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load_en,
    input  wire logic [SYM_W-1:0] load_sym,
    input  wire logic             clear_run,
    input  wire row_ctrl_t        in_ctrl,
    input  wire logic [SYM_W-1:0] in_sym,
    input  wire logic [CNT_W-1:0] in_n,
    input  wire logic [POS_W-1:0] in_pos,
    input  wire logic [LEN_W-1:0] in_diag,
    input  wire logic [LEN_W-1:0] in_best_len,
    input  wire logic [J_W-1:0]   in_best_j,
    output row_ctrl_t             out_ctrl,
    output logic      [SYM_W-1:0] out_sym,
    output logic      [CNT_W-1:0] out_n,
    output logic      [POS_W-1:0] out_pos,
    output logic      [LEN_W-1:0] out_diag,
    output logic      [LEN_W-1:0] out_best_len,
    output logic      [J_W-1:0]   out_best_j
);

    logic [SYM_W-1:0] char_reg;
    logic [LEN_W-1:0] run_reg;
    logic [LEN_W-1:0] run_next;
    row_ctrl_t        ctrl_reg;
    logic [SYM_W-1:0] sym_reg;
    logic [CNT_W-1:0] n_reg;
    logic [POS_W-1:0] pos_reg;
    logic [LEN_W-1:0] diag_reg;
    logic [LEN_W-1:0] best_len_reg;
    logic [LEN_W-1:0] best_len_next;
    logic [J_W-1:0]   best_j_reg;
    logic [J_W-1:0]   best_j_next;
    logic             active;
    logic             hit;

    always_comb begin
        // cells at or past the row's string length take no part
        active        = in_ctrl.valid && in_ctrl.compute;
        hit           = active && (in_n > CNT_W'(IDX)) && (char_reg == in_sym);
        run_next      = run_reg;
        best_len_next = in_best_len;
        best_j_next   = in_best_j;
        if (active) begin
            run_next = hit ? (in_diag + 1'b1) : '0;
            // strict compare keeps the lowest position on a tie
            if (run_next > in_best_len) begin
                best_len_next = run_next;
                best_j_next   = J_W'(IDX);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
            run_reg  <= '0;
        end else begin
            ctrl_reg <= in_ctrl;
            run_reg  <= clear_run ? '0 : run_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            char_reg <= load_sym;
        end
        sym_reg      <= in_sym;
        n_reg        <= in_n;
        pos_reg      <= in_pos;
        diag_reg     <= run_reg;
        best_len_reg <= best_len_next;
        best_j_reg   <= best_j_next;
    end

    assign out_ctrl     = ctrl_reg;
    assign out_sym      = sym_reg;
    assign out_n        = n_reg;
    assign out_pos      = pos_reg;
    assign out_diag     = diag_reg;
    assign out_best_len = best_len_reg;
    assign out_best_j   = best_j_reg;

endmodule
`default_nettype wire

>>> hdl/lcs_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_chain
// Systolic row of cells; each row of the table enters at cell zero and moves
// one cell per cycle, picking up the previous row's diagonal on the way.
// ----------------------------------------------------------------------------
module lcs_chain
    import lcs_pkg::*;
#(
    parameter int SECOND_MAX = 64,
    parameter int J_W        = 6,
    parameter int CNT_W      = 7,
    parameter int LEN_W      = 7,
    parameter int POS_W      = 12
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load_valid,
    input  wire logic [J_W-1:0]   load_addr,
    input  wire logic [SYM_W-1:0] load_sym,
    input  wire logic             clear_run,
    input  wire row_ctrl_t        in_ctrl,
    input  wire logic [SYM_W-1:0] in_sym,
    input  wire logic [CNT_W-1:0] in_n,
    input  wire logic [POS_W-1:0] in_pos,
    output row_ctrl_t             out_ctrl,
    output logic      [POS_W-1:0] out_pos,
    output logic      [LEN_W-1:0] out_best_len,
    output logic      [J_W-1:0]   out_best_j
);

    row_ctrl_t        ctrl_c     [SECOND_MAX+1];
    logic [SYM_W-1:0] sym_c      [SECOND_MAX+1];
    logic [CNT_W-1:0] n_c        [SECOND_MAX+1];
    logic [POS_W-1:0] pos_c      [SECOND_MAX+1];
    logic [LEN_W-1:0] diag_c     [SECOND_MAX+1];
    logic [LEN_W-1:0] best_len_c [SECOND_MAX+1];
    logic [J_W-1:0]   best_j_c   [SECOND_MAX+1];

    assign ctrl_c[0]     = in_ctrl;
    assign sym_c[0]      = in_sym;
    assign n_c[0]        = in_n;
    assign pos_c[0]      = in_pos;
    assign diag_c[0]     = '0;
    assign best_len_c[0] = '0;
    assign best_j_c[0]   = '0;

    for (genvar j = 0; j < SECOND_MAX; j++) begin : g_cell
        lcs_cell #(
            .IDX   (j),
            .J_W   (J_W),
            .CNT_W (CNT_W),
            .LEN_W (LEN_W),
            .POS_W (POS_W)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .load_en      (load_valid && (load_addr == J_W'(j))),
            .load_sym     (load_sym),
            .clear_run    (clear_run),
            .in_ctrl      (ctrl_c[j]),
            .in_sym       (sym_c[j]),
            .in_n         (n_c[j]),
            .in_pos       (pos_c[j]),
            .in_diag      (diag_c[j]),
            .in_best_len  (best_len_c[j]),
            .in_best_j    (best_j_c[j]),
            .out_ctrl     (ctrl_c[j+1]),
            .out_sym      (sym_c[j+1]),
            .out_n        (n_c[j+1]),
            .out_pos      (pos_c[j+1]),
            .out_diag     (diag_c[j+1]),
            .out_best_len (best_len_c[j+1]),
            .out_best_j   (best_j_c[j+1])
        );
    end

    assign out_ctrl     = ctrl_c[SECOND_MAX];
    assign out_pos      = pos_c[SECOND_MAX];
    assign out_best_len = best_len_c[SECOND_MAX];
    assign out_best_j   = best_j_c[SECOND_MAX];

endmodule
`default_nettype wire

>>> hdl/longest_common_substring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// longest_common_substring
// Longest common substring of a loaded second string and a streamed first
// string, by diagonal run lengths in a systolic row of cells.
// ----------------------------------------------------------------------------
// result: taken from the last item's row as it leaves the cell row, and
//   held in the output register
// throughput: one load or stream item per cycle; after a last item input
//   waits until its result is registered, a last stream item waits while
//   a result is held unaccepted, and a start item waits until the cell row has drained
// reset: control and run lengths clear at once, stored bytes stay unknown
// ----------------------------------------------------------------------------
module longest_common_substring
    import lcs_pkg::*;
#(
    parameter int SECOND_MAX = 64,
    parameter int FIRST_MAX  = 4096
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // op[1:0], symbol[9:2], zeros
    input  wire logic                 s_tlast,  // last
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // match_length[6:0], end_in_first[18:7], end_in_second[24:19],
    // found[25], overflow[26], zeros
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int J_W   = (SECOND_MAX > 1) ? $clog2(SECOND_MAX) : 1;
    localparam int CNT_W = $clog2(SECOND_MAX + 1);
    localparam int LEN_W = CNT_W;
    localparam int POS_W = (FIRST_MAX > 1) ? $clog2(FIRST_MAX) : 1;
    localparam int FIDX_W = $clog2(FIRST_MAX + 1);

    op_t              op;
    logic [SYM_W-1:0] symbol;
    logic             s_accept;
    logic             m_accept;

    logic [CNT_W-1:0]  count_reg,    count_next;
    logic [FIDX_W-1:0] first_idx_reg, first_idx_next;
    logic [CNT_W-1:0]  inflight_reg, inflight_next;
    logic              ovf_reg,      ovf_next;
    logic              busy_last_reg, busy_last_next;
    logic [LEN_W-1:0]  glob_len_reg, glob_len_next;
    logic [POS_W-1:0]  glob_pos_reg, glob_pos_next;
    logic [J_W-1:0]    glob_j_reg,   glob_j_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic              load_valid;
    logic              clear_run;
    row_ctrl_t         in_ctrl;
    row_ctrl_t         out_ctrl;
    logic [POS_W-1:0]  out_pos;
    logic [LEN_W-1:0]  out_best_len;
    logic [J_W-1:0]    out_best_j;
    logic              row_exit;
    logic              last_exit;
    logic              inject;

    logic [LEN_W+LEN_OUT_W-1:0]     len_ext;
    logic [POS_W+FIRST_OUT_W-1:0]   pos_ext;
    logic [J_W+SECOND_OUT_W-1:0]    j_ext;

    assign op       = op_t'(s_tdata[OP_W-1:0]);
    assign symbol   = s_tdata[OP_W+SYM_W-1:OP_W];
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid_reg && m_tready;

    always_comb begin
        s_tready = !busy_last_reg;
        case (op)
            OP_START:  if (inflight_reg != '0) s_tready = 1'b0;
            OP_STREAM: if (s_tlast && m_tvalid_reg) s_tready = 1'b0;
            default:   ;
        endcase
    end

    assign load_valid = s_accept && (op == OP_LOAD) && (count_reg < CNT_W'(SECOND_MAX));
    assign inject     = s_accept && (op == OP_STREAM);
    assign row_exit   = out_ctrl.valid;
    assign last_exit  = out_ctrl.valid && out_ctrl.last;
    assign clear_run  = (s_accept && (op == OP_START)) || last_exit;

    always_comb begin
        in_ctrl.valid   = inject;
        in_ctrl.compute = first_idx_reg < FIDX_W'(FIRST_MAX);
        in_ctrl.last    = s_tlast;
    end

    lcs_chain #(
        .SECOND_MAX (SECOND_MAX),
        .J_W        (J_W),
        .CNT_W      (CNT_W),
        .LEN_W      (LEN_W),
        .POS_W      (POS_W)
    ) u_chain (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load_valid   (load_valid),
        .load_addr    (count_reg[J_W-1:0]),
        .load_sym     (symbol),
        .clear_run    (clear_run),
        .in_ctrl      (in_ctrl),
        .in_sym       (symbol),
        .in_n         (count_reg),
        .in_pos       (first_idx_reg[POS_W-1:0]),
        .out_ctrl     (out_ctrl),
        .out_pos      (out_pos),
        .out_best_len (out_best_len),
        .out_best_j   (out_best_j)
    );

    always_comb begin
        count_next     = count_reg;
        first_idx_next = first_idx_reg;
        ovf_next       = ovf_reg;
        busy_last_next = busy_last_reg;
        inflight_next  = inflight_reg + CNT_W'(inject) - CNT_W'(row_exit);
        glob_len_next  = glob_len_reg;
        glob_pos_next  = glob_pos_reg;
        glob_j_next    = glob_j_reg;
        m_tvalid_next  = m_tvalid_reg && !m_accept;
        m_tdata_next   = m_tdata_reg;

        // rows leave the cell row in order; earlier rows win ties
        if (out_ctrl.valid && out_ctrl.compute && (out_best_len > glob_len_reg)) begin
            glob_len_next = out_best_len;
            glob_pos_next = out_pos;
            glob_j_next   = out_best_j;
        end

        len_ext = {{LEN_OUT_W{1'b0}}, glob_len_next};
        pos_ext = {{FIRST_OUT_W{1'b0}}, glob_pos_next};
        j_ext   = {{SECOND_OUT_W{1'b0}}, glob_j_next};

        if (last_exit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {
                {(M_TDATA_W - LEN_OUT_W - FIRST_OUT_W - SECOND_OUT_W - 2){1'b0}},
                ovf_reg,
                (glob_len_next != '0),
                j_ext[SECOND_OUT_W-1:0],
                pos_ext[FIRST_OUT_W-1:0],
                len_ext[LEN_OUT_W-1:0]
            };
            glob_len_next  = '0;
            glob_pos_next  = '0;
            glob_j_next    = '0;
            first_idx_next = '0;
            busy_last_next = 1'b0;
        end

        if (s_accept) begin
            unique case (op)
                OP_START: begin
                    count_next     = '0;
                    first_idx_next = '0;
                    ovf_next       = 1'b0;
                    glob_len_next  = '0;
                    glob_pos_next  = '0;
                    glob_j_next    = '0;
                end
                OP_LOAD: begin
                    if (count_reg < CNT_W'(SECOND_MAX)) begin
                        count_next = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                OP_STREAM: begin
                    if (first_idx_reg < FIDX_W'(FIRST_MAX)) begin
                        first_idx_next = first_idx_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        busy_last_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            first_idx_reg <= '0;
            inflight_reg  <= '0;
            ovf_reg       <= 1'b0;
            busy_last_reg <= 1'b0;
            glob_len_reg  <= '0;
            glob_pos_reg  <= '0;
            glob_j_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            count_reg     <= count_next;
            first_idx_reg <= first_idx_next;
            inflight_reg  <= inflight_next;
            ovf_reg       <= ovf_next;
            busy_last_reg <= busy_last_next;
            glob_len_reg  <= glob_len_next;
            glob_pos_reg  <= glob_pos_next;
            glob_j_reg    <= glob_j_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_result_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $fell(busy_last_reg))
        else $error("result raised without a pending last item");

    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= CNT_W'(SECOND_MAX))
        else $error("more rows in flight than cells");

    a_exit_tracked: assert property (@(posedge aclk) disable iff (!aresetn)
        out_ctrl.valid |-> (inflight_reg != '0))
        else $error("row left the cell row without being counted");

endmodule
`default_nettype wire

>>> sim/tb_longest_common_substring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_common_substring
// Self-checking bench for the longest common substring block. A short table
// of directed items is followed by random problems: a start, a loaded second
// string, then one or more streamed first strings that often carry copies of
// slices of the second string. A scoreboard model of the diagonal run lengths
// predicts each untyped result; every result item is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_longest_common_substring
    import lcs_pkg::*;
();

    localparam int SECOND_CAP     = 64;
    localparam int FIRST_CAP      = 4096;
    localparam int ITEM_TARGET    = 1000;
    localparam int QUIET_ITEMS    = 150;
    localparam int MIN_RESULTS    = 48;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DIR_N          = 20;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [LEN_OUT_W-1:0]    match_length;
        logic [FIRST_OUT_W-1:0]  end_in_first;
        logic [SECOND_OUT_W-1:0] end_in_second;
        logic                    found;
        logic                    overflow;
    } lcs_result_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SYM_W-1:0] sym;
        logic             last;
        logic             typed;
        lcs_result_t      result;
    } dir_row_t;

    localparam lcs_result_t NO_RESULT = '0;

    // typed results only where they are obvious; the rest go through the model
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{OP_STREAM, 8'h00, 1'b1, 1'b1, NO_RESULT},      // no second string yet
        '{OP_UNUSED, 8'hFF, 1'b1, 1'b0, NO_RESULT},
        '{OP_START,  8'hA5, 1'b1, 1'b0, NO_RESULT},      // last ignored on start
        '{OP_LOAD,   8'h00, 1'b1, 1'b0, NO_RESULT},      // last ignored on load
        '{OP_LOAD,   8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{OP_LOAD,   8'h5A, 1'b0, 1'b0, NO_RESULT},
        '{OP_STREAM, 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{OP_STREAM, 8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{OP_STREAM, 8'h5A, 1'b1, 1'b1, '{7'd3, 12'd2, 6'd2, 1'b1, 1'b0}},
        '{OP_STREAM, 8'h77, 1'b1, 1'b1, NO_RESULT},      // no match at all
        '{OP_STREAM, 8'h5A, 1'b0, 1'b0, NO_RESULT},
        '{OP_LOAD,   8'h5A, 1'b0, 1'b0, NO_RESULT},      // append while streaming
        '{OP_STREAM, 8'h5A, 1'b1, 1'b0, NO_RESULT},
        '{OP_STREAM, 8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{OP_STREAM, 8'hFF, 1'b1, 1'b0, NO_RESULT},      // tie keeps earliest
        '{OP_STREAM, 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{OP_STREAM, 8'h5A, 1'b0, 1'b0, NO_RESULT},
        '{OP_STREAM, 8'h5A, 1'b1, 1'b0, NO_RESULT},
        '{OP_START,  8'h00, 1'b0, 1'b0, NO_RESULT},
        '{OP_STREAM, 8'h42, 1'b1, 1'b1, NO_RESULT}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // scoreboard model state
    logic [SYM_W-1:0]     second_bytes [SECOND_CAP];
    int                   second_len;
    logic [LEN_OUT_W-1:0] diag_run [SECOND_CAP];
    int                   first_pos;
    logic [LEN_OUT_W-1:0] best_len;
    int                   best_first;
    int                   best_second;
    logic                 trunc_flag;

    lcs_result_t expected_results[$];

    int errors            = 0;
    int items_sent        = 0;
    int results_predicted = 0;
    int idle_cycles       = 0;
    int hold_left         = 0;
    int rx_gap            = 0;
    int rx_cycle          = 0;
    bit quiet             = 1'b0;
    bit tx_gappy          = 1'b1;
    bit rx_gappy          = 1'b1;
    bit hold_request      = 1'b0;

    longest_common_substring #(
        .SECOND_MAX(SECOND_CAP),
        .FIRST_MAX (FIRST_CAP)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void clear_stream();
        int j;
        for (j = 0; j < SECOND_CAP; j++) begin
            diag_run[j] = '0;
        end
        first_pos   = 0;
        best_len    = '0;
        best_first  = 0;
        best_second = 0;
    endfunction

    // advances the model by one accepted item, returns 1 when a result is due
    function automatic bit lcs_advance(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                       input logic last, output lcs_result_t res);
        logic [LEN_OUT_W-1:0] row [SECOND_CAP];
        int j;
        res = '0;
        if (op == OP_START) begin
            second_len = 0;
            trunc_flag = 1'b0;
            clear_stream();
        end else if (op == OP_LOAD) begin
            if (second_len < SECOND_CAP) begin
                second_bytes[second_len] = sym;
                second_len++;
            end else begin
                trunc_flag = 1'b1;
            end
        end else if (op == OP_STREAM) begin
            if (first_pos < FIRST_CAP) begin
                for (j = 0; j < second_len; j++) begin
                    if (second_bytes[j] != sym) begin
                        row[j] = '0;
                    end else begin
                        row[j] = (j > 0) ? diag_run[j-1] + 7'd1 : 7'd1;
                    end
                    if (row[j] > best_len) begin
                        best_len    = row[j];
                        best_first  = first_pos;
                        best_second = j;
                    end
                end
                for (j = 0; j < second_len; j++) begin
                    diag_run[j] = row[j];
                end
                first_pos++;
            end else begin
                trunc_flag = 1'b1;
            end
            if (last) begin
                res.match_length  = best_len;
                res.end_in_first  = FIRST_OUT_W'(best_first);
                res.end_in_second = SECOND_OUT_W'(best_second);
                res.found         = (best_len != '0);
                res.overflow      = trunc_flag;
                clear_stream();
                results_predicted++;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic push_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                             input logic last, input logic typed = 1'b0,
                             input lcs_result_t typed_result = '0);
        lcs_result_t res;
        if (tx_gappy && !quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'($urandom);
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-OP_W-SYM_W){1'b0}}, sym, op};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (lcs_advance(op, sym, last, res)) begin
            expected_results.push_back(typed ? typed_result : res);
        end
        if (op != OP_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    task automatic run_problem();
        logic [SYM_W-1:0] text[$];
        logic [SYM_W-1:0] mask;
        logic [SYM_W-1:0] base;
        logic [SYM_W-1:0] sym;
        int n_load;
        int len;
        int plant;
        int pick;
        int k;
        bit hold_last;
        tx_gappy = !quiet && ($urandom_range(0, 2) != 0);
        push_item(OP_START, SYM_W'($urandom), ($urandom_range(0, 3) == 0));
        case ($urandom_range(0, 2))
            0: begin
                mask = 8'h01;
            end
            1: begin
                mask = 8'h03;
            end
            default: begin
                mask = 8'hFF;
            end
        endcase
        base = SYM_W'($urandom);
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            n_load = $urandom_range(SECOND_CAP, SECOND_CAP + 4);
        end else if (pick < 4) begin
            n_load = $urandom_range(13, SECOND_CAP - 1);
        end else begin
            n_load = $urandom_range(1, 12);
        end
        repeat (n_load) begin
            sym = base ^ (SYM_W'($urandom) & mask);
            if (text.size() < SECOND_CAP) begin
                text.push_back(sym);
            end
            push_item(OP_LOAD, sym, ($urandom_range(0, 7) == 0));
        end
        repeat ($urandom_range(1, 3)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 16);
            // now and then a first string runs on into the next one
            hold_last = ($urandom_range(0, 15) == 0);
            plant = -1;
            for (k = 0; k < len; k++) begin
                pick = $urandom_range(0, 79);
                if (pick < 2) begin
                    push_item(OP_UNUSED, SYM_W'($urandom), 1'($urandom_range(0, 1)));
                end else if (pick == 2 && text.size() < SECOND_CAP) begin
                    sym = base ^ (SYM_W'($urandom) & mask);
                    text.push_back(sym);
                    push_item(OP_LOAD, sym, 1'b0);
                end else if (pick == 3) begin
                    push_item(OP_START, SYM_W'($urandom), 1'b0);
                end
                // copy a slice of the second string to build long runs
                if (plant < 0 && $urandom_range(0, 5) == 0) begin
                    plant = $urandom_range(0, 1) ? 0 : $urandom_range(0, text.size() - 1);
                end
                if (plant >= 0 && plant < text.size()) begin
                    sym = text[plant];
                    plant++;
                end else begin
                    sym = base ^ (SYM_W'($urandom) & mask);
                    plant = -1;
                end
                push_item(OP_STREAM, sym, (k == len - 1) && !hold_last);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp,
                               input logic [31:0] act);
        if (act !== exp) begin
            errors++;
            $display("%0t ns: %s expected %0d got %0d", $time, name, exp, act);
        end
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] data);
        lcs_result_t want;
        if (expected_results.size() == 0) begin
            errors++;
            $display("%0t ns: result item expected none got %h", $time, data);
        end else begin
            want = expected_results.pop_front();
            check_field("match_length", 32'(want.match_length), 32'(data[6:0]));
            check_field("end_in_first", 32'(want.end_in_first), 32'(data[18:7]));
            check_field("end_in_second", 32'(want.end_in_second), 32'(data[24:19]));
            check_field("found", 32'(want.found), 32'(data[25]));
            check_field("overflow", 32'(want.overflow), 32'(data[26]));
        end
    endtask

    // result side: checks accepted items and paces m_tready
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            rx_cycle++;
            if (rx_cycle % 300 == 0) begin
                rx_gappy = ($urandom_range(0, 2) != 0);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else if (rx_gappy && $urandom_range(0, 4) == 0) begin
                rx_gap = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no item moved for %0d cycles", $time, idle_cycles);
                $display("longest_common_substring: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int r;
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (r = 0; r < DIR_N; r++) begin
            push_item(DIR_ROWS[r].op, DIR_ROWS[r].sym, DIR_ROWS[r].last,
                      DIR_ROWS[r].typed, DIR_ROWS[r].result);
        end

        items_sent = 0;
        while (items_sent < ITEM_TARGET || results_predicted < MIN_RESULTS) begin
            if (!hold_done && items_sent > 300) begin
                // output blocked for a long stretch while items keep coming
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pause_done && items_sent > 600) begin
                wait_for_results();
                pause_done = 1'b1;
            end
            run_problem();
        end

        quiet = 1'b1;
        items_sent = 0;
        while (items_sent < QUIET_ITEMS) begin
            run_problem();
        end

        wait_for_results();
        repeat (SECOND_CAP + 8) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("longest_common_substring: match");
        end else begin
            if (expected_results.size() != 0) begin
                $display("%0t ns: %0d result items never arrived", $time,
                         expected_results.size());
            end
            $display("longest_common_substring: mismatch");
        end
        $finish;
    end

endmodule

>>> longest_common_substring.f
hdl/lcs_pkg.sv
hdl/lcs_cell.sv
hdl/lcs_chain.sv
hdl/longest_common_substring.sv
sim/tb_longest_common_substring.sv
